@@ rtl/signed_int_to_decimal_ascii_macros.svh @@
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_macros.svh
// Assertion macros shared by the decimal converter modules.
// ----------------------------------------------------------------------------
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_MACROS_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_MACROS_SVH

`ifndef NO_ASSERTIONS
`define SITOA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define SITOA_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SITOA_ASSERT_IMP(label, ante, cons, msg)
`define SITOA_ASSERT_NXT(label, ante, cons, msg)
`endif

`endif

@@ rtl/sitoa_pkg.sv @@
// ----------------------------------------------------------------------------
// sitoa_pkg
// Shared constants and types of the signed integer to decimal ASCII converter.
// ----------------------------------------------------------------------------
package sitoa_pkg;

  localparam int unsigned VALUE_WIDTH = 32;
  // decimal digits of any VALUE_WIDTH-bit unsigned magnitude
  localparam int unsigned NUM_DIGITS  = (VALUE_WIDTH * 30103) / 100000 + 1;
  localparam int unsigned BCD_WIDTH   = NUM_DIGITS * 4;
  localparam int unsigned DIG_IDX_W   = $clog2(NUM_DIGITS);
  localparam int unsigned BIT_CNT_W   = $clog2(VALUE_WIDTH);

  localparam int unsigned FIFO_DEPTH  = 2;
  localparam int unsigned FIFO_PTR_W  = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

  localparam logic [7:0] CHAR_MINUS = 8'd45;
  localparam logic [7:0] CHAR_ZERO  = 8'd48;

  typedef struct packed {
    logic                   neg;
    logic [VALUE_WIDTH-1:0] mag;
  } num_t;

  typedef struct packed {
    logic valid;
    num_t num;
  } num_word_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_CONV,
    B_SIZE,
    B_SIGN,
    B_DIGIT
  } back_state_e;

endpackage

@@ rtl/sitoa_front.sv @@
// ----------------------------------------------------------------------------
// sitoa_front
// Input stage: takes a word, splits it into sign and unsigned magnitude.
// ----------------------------------------------------------------------------
module sitoa_front (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      in_valid_i,
  output logic                                      in_stall_o,
  input  logic signed [sitoa_pkg::VALUE_WIDTH-1:0]  value_i,
  input  logic                                      fifo_full_i,
  output sitoa_pkg::num_word_t                      push_o
);

  localparam int unsigned W = sitoa_pkg::VALUE_WIDTH;

  logic            valid_q, valid_d;
  sitoa_pkg::num_t num_q, num_d;
  logic            take;
  logic            push;
  logic [W-1:0]    uval;

  assign in_stall_o = valid_q && fifo_full_i;
  assign take       = in_valid_i && !in_stall_o;
  assign push       = valid_q && !fifo_full_i;
  assign uval       = value_i;

  always_comb begin
    num_d   = num_q;
    valid_d = valid_q;
    if (push) begin
      valid_d = 1'b0;
    end
    if (take) begin
      valid_d     = 1'b1;
      num_d.neg   = uval[W-1];
      num_d.mag   = uval[W-1] ? (~uval + {{(W-1){1'b0}}, 1'b1}) : uval;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
  end

  assign push_o.valid = push;
  assign push_o.num   = num_q;

endmodule

@@ rtl/sitoa_fifo.sv @@
// ----------------------------------------------------------------------------
// sitoa_fifo
// Short queue of sign/magnitude words between the front and back parts.
// ----------------------------------------------------------------------------
`include "signed_int_to_decimal_ascii_macros.svh"

module sitoa_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  sitoa_pkg::num_word_t push_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output sitoa_pkg::num_word_t head_o
);

  localparam int unsigned                   PTR_W    = sitoa_pkg::FIFO_PTR_W;
  localparam int unsigned                   CNT_W    = sitoa_pkg::FIFO_CNT_W;
  localparam logic [PTR_W-1:0]              PTR_LAST = PTR_W'(sitoa_pkg::FIFO_DEPTH - 1);
  localparam logic [CNT_W-1:0]              CNT_FULL = CNT_W'(sitoa_pkg::FIFO_DEPTH);

  sitoa_pkg::num_t   mem_q [sitoa_pkg::FIFO_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              do_push;
  logic              do_pop;

  assign full_o  = (cnt_q == CNT_FULL);
  assign do_push = push_i.valid && !full_o;
  assign do_pop  = pop_i && (cnt_q != '0);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.num;
    end
  end

  assign head_o.valid = (cnt_q != '0);
  assign head_o.num   = mem_q[rd_ptr_q];

  `SITOA_ASSERT_IMP(a_no_push_full, push_i.valid, !full_o, "front pushed into full queue")
  `SITOA_ASSERT_IMP(a_no_pop_empty, pop_i, cnt_q != '0, "back popped empty queue")

endmodule

@@ rtl/sitoa_back.sv @@
// ----------------------------------------------------------------------------
// sitoa_back
// Converts a magnitude to BCD by shift-and-add-3, then emits the characters.
// ----------------------------------------------------------------------------
`include "signed_int_to_decimal_ascii_macros.svh"

module sitoa_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  sitoa_pkg::num_word_t head_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [7:0]           char_code_o,
  output logic                 last_o
);

  localparam int unsigned          W      = sitoa_pkg::VALUE_WIDTH;
  localparam int unsigned          ND     = sitoa_pkg::NUM_DIGITS;
  localparam int unsigned          BW     = sitoa_pkg::BCD_WIDTH;
  localparam int unsigned          IDX_W  = sitoa_pkg::DIG_IDX_W;
  localparam int unsigned          CNT_W  = sitoa_pkg::BIT_CNT_W;
  localparam logic [CNT_W-1:0]     CNT_LAST = CNT_W'(W - 1);

  sitoa_pkg::back_state_e state_q, state_d;
  logic             neg_q, neg_d;
  logic [W-1:0]     mag_q, mag_d;
  logic [BW-1:0]    bcd_q, bcd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic             out_valid_q, out_valid_d;
  logic [7:0]       char_q, char_d;
  logic             last_q, last_d;

  logic             out_free;
  logic             load_out;
  logic [BW-1:0]    adj;
  logic [IDX_W-1:0] top;
  logic [3:0]       cur_digit;

  assign out_free = !out_valid_q || !out_stall_i;

  // add-3 correction per digit and leading digit position
  always_comb begin
    adj = bcd_q;
    top = '0;
    for (int i = 0; i < ND; i++) begin
      if (bcd_q[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
      end
      if (bcd_q[4*i +: 4] != 4'd0) begin
        top = IDX_W'(i);
      end
    end
  end

  assign cur_digit = bcd_q[{idx_q, 2'b00} +: 4];

  always_comb begin
    state_d = state_q;
    case (state_q)
      sitoa_pkg::B_IDLE: begin
        if (head_i.valid) state_d = sitoa_pkg::B_CONV;
      end
      sitoa_pkg::B_CONV: begin
        if (cnt_q == CNT_LAST) state_d = sitoa_pkg::B_SIZE;
      end
      sitoa_pkg::B_SIZE: begin
        state_d = neg_q ? sitoa_pkg::B_SIGN : sitoa_pkg::B_DIGIT;
      end
      sitoa_pkg::B_SIGN: begin
        if (out_free) state_d = sitoa_pkg::B_DIGIT;
      end
      sitoa_pkg::B_DIGIT: begin
        if (out_free && idx_q == '0) state_d = sitoa_pkg::B_IDLE;
      end
      default: state_d = sitoa_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    pop_o    = 1'b0;
    load_out = 1'b0;
    neg_d    = neg_q;
    mag_d    = mag_q;
    bcd_d    = bcd_q;
    cnt_d    = cnt_q;
    idx_d    = idx_q;
    char_d   = char_q;
    last_d   = last_q;
    case (state_q)
      sitoa_pkg::B_IDLE: begin
        if (head_i.valid) begin
          pop_o = 1'b1;
          neg_d = head_i.num.neg;
          mag_d = head_i.num.mag;
          bcd_d = '0;
          cnt_d = '0;
        end
      end
      sitoa_pkg::B_CONV: begin
        bcd_d = {adj[BW-2:0], mag_q[W-1]};
        mag_d = {mag_q[W-2:0], 1'b0};
        cnt_d = cnt_q + 1'b1;
      end
      sitoa_pkg::B_SIZE: begin
        idx_d = top;
      end
      sitoa_pkg::B_SIGN: begin
        if (out_free) begin
          load_out = 1'b1;
          char_d   = sitoa_pkg::CHAR_MINUS;
          last_d   = 1'b0;
        end
      end
      sitoa_pkg::B_DIGIT: begin
        if (out_free) begin
          load_out = 1'b1;
          char_d   = sitoa_pkg::CHAR_ZERO + {4'b0000, cur_digit};
          last_d   = (idx_q == '0);
          idx_d    = idx_q - 1'b1;
        end
      end
      default: begin
        pop_o = 1'b0;
      end
    endcase
    out_valid_d = load_out ? 1'b1 : (out_free ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sitoa_pkg::B_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q  <= neg_d;
    mag_q  <= mag_d;
    bcd_q  <= bcd_d;
    cnt_q  <= cnt_d;
    idx_q  <= idx_d;
    char_q <= char_d;
    last_q <= last_d;
  end

  assign out_valid_o = out_valid_q;
  assign char_code_o = char_q;
  assign last_o      = last_q;

  `SITOA_ASSERT_IMP(a_char_range, out_valid_o, (char_code_o == sitoa_pkg::CHAR_MINUS) || (char_code_o >= sitoa_pkg::CHAR_ZERO && char_code_o <= sitoa_pkg::CHAR_ZERO + 8'd9), "output word is not a digit or minus")
  `SITOA_ASSERT_IMP(a_minus_neg, out_valid_o && char_code_o == sitoa_pkg::CHAR_MINUS, neg_q && !last_o, "minus word on positive number or marked last")
  `SITOA_ASSERT_NXT(a_conv_exit, state_q == sitoa_pkg::B_CONV, state_q == sitoa_pkg::B_CONV || state_q == sitoa_pkg::B_SIZE, "conversion left to wrong state")

endmodule

@@ rtl/signed_int_to_decimal_ascii.sv @@
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// Signed integer to decimal ASCII character stream.
// ----------------------------------------------------------------------------
// Input channel: in_valid_i / in_stall_o carry one signed word value_i.
// Output channel: out_valid_o / out_stall_i carry one character per word,
// char_code_o ('-' or '0'..'9'), most significant digit first, no leading
// zeros; last_o marks the final character of a number.
// A front register and a two-entry queue hold up to three numbers ahead of
// the converter, so input is taken while the converter works.
// The converter pops a number, runs one shift-and-add-3 step per bit, sizes
// the digit run and then emits the characters, waiting while the output is
// stalled; it pops the next number only once its last character is loaded.
// Reset clears the valid flags, queue pointers and converter state; the queue and output register are empty.
// A stalled output holds its word; the converter waits and the queue fills,
// after which in_stall_o rises.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     in_valid_i,
  output logic                                     in_stall_o,
  input  logic signed [sitoa_pkg::VALUE_WIDTH-1:0] value_i,
  output logic                                     out_valid_o,
  input  logic                                     out_stall_i,
  output logic [7:0]                               char_code_o,
  output logic                                     last_o
);

  sitoa_pkg::num_word_t push;
  sitoa_pkg::num_word_t head;
  logic                 fifo_full;
  logic                 pop;

  sitoa_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .value_i     (value_i),
    .fifo_full_i (fifo_full),
    .push_o      (push)
  );

  sitoa_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .full_o (fifo_full),
    .pop_i  (pop),
    .head_o (head)
  );

  sitoa_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .char_code_o (char_code_o),
    .last_o      (last_o)
  );

endmodule
